### rtl/core/ahts_pkg.sv
`timescale 1ns / 1ps

package ahts_pkg;

  // Window geometry
  localparam int unsigned WINDOW_LEN  = 10;
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned POS_W  = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int unsigned AVG_W  = 9;
  localparam int unsigned AVG_MULT  = 25;
  localparam int unsigned AVG_SHIFT = 9;
  localparam int unsigned PROD_W = (SUM_W + 5 > AVG_SHIFT + AVG_W) ? SUM_W + 5
                                                                  : AVG_SHIFT + AVG_W;

  // Field widths
  localparam int unsigned SP_W    = 7;
  localparam int unsigned BAND_W  = 5;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned SECS_W  = 4;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_BAND     = 3'd0;
  localparam logic [2:0] REG_STEP     = 3'd1;
  localparam logic [2:0] REG_SP_MIN   = 3'd2;
  localparam logic [2:0] REG_SP_MAX   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;
  localparam logic [2:0] REG_RESUME   = 3'd5;
  localparam logic [2:0] REG_INIT_SP  = 3'd6;

  localparam logic [BAND_W-1:0] RST_BAND    = 5'd5;
  localparam logic [STEP_W-1:0] RST_STEP    = 4'd5;
  localparam logic [SP_W-1:0]   RST_SP_MIN  = 7'd35;
  localparam logic [SP_W-1:0]   RST_SP_MAX  = 7'd65;
  localparam logic [SECS_W-1:0] RST_TIMEOUT = 4'd5;
  localparam logic [SECS_W-1:0] RST_RESUME  = 4'd4;
  localparam logic [SP_W-1:0]   RST_INIT_SP = 7'd60;

  localparam logic [SECS_W-1:0] SECS_MAX = 4'hF;

  // Request action codes
  localparam logic [2:0] ACT_SAMPLE = 3'd0;
  localparam logic [2:0] ACT_KEY    = 3'd1;
  localparam logic [2:0] ACT_SECOND = 3'd2;
  localparam logic [2:0] ACT_BLINK  = 3'd3;
  localparam logic [2:0] ACT_POWER  = 3'd4;

  // Key codes
  localparam logic [1:0] KEY_UP   = 2'd1;
  localparam logic [1:0] KEY_DOWN = 2'd2;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_HEAT = 2'd1,
    MODE_COOL = 2'd2
  } ahts_mode_e;

  typedef struct packed {
    logic [2:0]             action;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [1:0]             key;
  } ahts_in_t;

  typedef struct packed {
    logic             heater_on;
    logic             fan_on;
    logic             led_on;
    logic [1:0]       heat_cool_mode;
    logic             setting_active;
    logic [SP_W-1:0]  setpoint;
    logic [AVG_W-1:0] avg_temperature;
    logic             warming_up;
    logic             store_request;
  } ahts_out_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [STEP_W-1:0] step;
    logic [SP_W-1:0]   sp_min;
    logic [SP_W-1:0]   sp_max;
    logic [SECS_W-1:0] timeout;
    logic [SECS_W-1:0] resume;
    logic [SP_W-1:0]   init_sp;
  } ahts_cfg_t;

  // Window state after the current request
  typedef struct packed {
    logic             warmup;
    logic [AVG_W-1:0] avg;
  } ahts_win_t;

endpackage

### rtl/core/ahts_cell.sv
`timescale 1ns / 1ps

module ahts_cell import ahts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] d_i,
  output logic [SAMPLE_BITS-1:0] q_o
);

  logic [SAMPLE_BITS-1:0] sample_q;

  // Take the neighbor's sample on a shift, hold otherwise
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= d_i;
    end
  end

  assign q_o = sample_q;

endmodule

### rtl/core/ahts_window.sv
`timescale 1ns / 1ps

module ahts_window import ahts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic                   clear_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output ahts_win_t              nxt_o
);

  logic [SAMPLE_BITS-1:0] tap [WINDOW_LEN+1];
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   warmup_q, warmup_d;
  logic [PROD_W-1:0]      prod;

  assign tap[0] = sample_i;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    ahts_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (take_i),
      .d_i     (tap[i]),
      .q_o     (tap[i+1])
    );
  end

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    warmup_d = warmup_q;
    if (clear_i) begin
      pos_d    = '0;
      sum_d    = '0;
      warmup_d = 1'b1;
    end else if (take_i) begin
      // Drop the oldest sample only once the window is full
      sum_d = sum_q - (warmup_q ? '0 : SUM_W'(tap[WINDOW_LEN])) + SUM_W'(sample_i);
      if (pos_q == POS_W'(WINDOW_LEN - 1)) begin
        pos_d    = '0;
        warmup_d = 1'b0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign prod = PROD_W'(sum_d) * PROD_W'(AVG_MULT);

  assign nxt_o.warmup = warmup_d;
  assign nxt_o.avg    = prod[AVG_SHIFT +: AVG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= '0;
      warmup_q <= 1'b1;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      warmup_q <= warmup_d;
    end
  end

  // A power off leaves an empty window behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (warmup_q && sum_q == '0 && pos_q == '0))
    else $error("window not emptied after clear");

  // While filling, the sum never exceeds what the filled cells can hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    warmup_q |-> (sum_q <= SUM_W'(pos_q) * SUM_W'((1 << SAMPLE_BITS) - 1)))
    else $error("window sum too large for fill count");

endmodule

### rtl/core/ahts_apb_regs.sv
`timescale 1ns / 1ps

module ahts_apb_regs import ahts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output ahts_cfg_t             cfg_o
);

  ahts_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band    <= RST_BAND;
      cfg_q.step    <= RST_STEP;
      cfg_q.sp_min  <= RST_SP_MIN;
      cfg_q.sp_max  <= RST_SP_MAX;
      cfg_q.timeout <= RST_TIMEOUT;
      cfg_q.resume  <= RST_RESUME;
      cfg_q.init_sp <= RST_INIT_SP;
    end else if (wr_en) begin
      unique case (idx)
        REG_BAND:    cfg_q.band    <= pwdata[BAND_W-1:0];
        REG_STEP:    cfg_q.step    <= pwdata[STEP_W-1:0];
        REG_SP_MIN:  cfg_q.sp_min  <= pwdata[SP_W-1:0];
        REG_SP_MAX:  cfg_q.sp_max  <= pwdata[SP_W-1:0];
        REG_TIMEOUT: cfg_q.timeout <= pwdata[SECS_W-1:0];
        REG_RESUME:  cfg_q.resume  <= pwdata[SECS_W-1:0];
        REG_INIT_SP: cfg_q.init_sp <= pwdata[SP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BAND:    prdata = APB_DATA_W'(cfg_q.band);
      REG_STEP:    prdata = APB_DATA_W'(cfg_q.step);
      REG_SP_MIN:  prdata = APB_DATA_W'(cfg_q.sp_min);
      REG_SP_MAX:  prdata = APB_DATA_W'(cfg_q.sp_max);
      REG_TIMEOUT: prdata = APB_DATA_W'(cfg_q.timeout);
      REG_RESUME:  prdata = APB_DATA_W'(cfg_q.resume);
      REG_INIT_SP: prdata = APB_DATA_W'(cfg_q.init_sp);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/averaged_hysteresis_thermostat_core.sv
`timescale 1ns / 1ps
// An accepted result goes to the output register, or to the skid entry if that is busy.
// Throughput: one request per cycle while the skid entry is empty, set by the update of
// the sample chain and running sum; two output entries (register plus skid) absorb stalls.
// Reset: rst_ni is asynchronous, active low; it empties the window, clears all drive
// and mode state, loads the setpoint with 60 and the registers with their defaults.

module averaged_hysteresis_thermostat_core import ahts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ahts_in_t              in_req_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ahts_out_t             out_rsp_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  ahts_cfg_t cfg;
  ahts_win_t win;

  // Control state
  logic              setting_q, setting_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic [SP_W-1:0]   setpoint_q, setpoint_d;
  ahts_mode_e        mode_q, mode_d;
  logic              heater_q, heater_d;
  logic              fan_q, fan_d;
  logic              led_q, led_d;

  // Output stage
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  ahts_out_t out_q, out_d;
  ahts_out_t skid_q, skid_d;
  ahts_out_t rsp;

  logic              accept;
  logic              out_take;
  logic              take;
  logic              clear;
  logic              store;
  logic              blink;
  logic              run;
  logic signed [8:0] sp_step;
  logic [SECS_W-1:0] secs_inc;
  logic signed [10:0] avg_s, hi_s, lo_s;

  ahts_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The skid entry being full is the only reason to stall the request side
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // A sample enters the window unless setting mode is still masking samples
  assign take  = accept && (in_req_i.action == ACT_SAMPLE) &&
                 !(setting_q && (secs_q < cfg.resume));
  assign clear = accept && (in_req_i.action == ACT_POWER);

  ahts_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .clear_i  (clear),
    .sample_i (in_req_i.adc_sample),
    .nxt_o    (win)
  );

  assign secs_inc = (secs_q == SECS_MAX) ? secs_q : secs_q + SECS_W'(1);

  // Request handling, then the bang-bang controller on the updated state
  always_comb begin
    setting_d  = setting_q;
    secs_d     = secs_q;
    setpoint_d = setpoint_q;
    mode_d     = mode_q;
    heater_d   = heater_q;
    fan_d      = fan_q;
    led_d      = led_q;
    store      = 1'b0;
    blink      = 1'b0;
    run        = 1'b0;
    sp_step    = $signed({2'b00, setpoint_q});
    avg_s      = '0;
    hi_s       = '0;
    lo_s       = '0;

    if (accept) begin
      unique case (in_req_i.action)
        ACT_SAMPLE: begin
          run = 1'b1;
        end
        ACT_KEY: begin
          run = 1'b1;
          if (!setting_q) begin
            // First key only wakes up setting mode
            setting_d = 1'b1;
          end else begin
            if (in_req_i.key == KEY_UP) begin
              sp_step = $signed({2'b00, setpoint_q}) + $signed({5'b00000, cfg.step});
            end else if (in_req_i.key == KEY_DOWN) begin
              sp_step = $signed({2'b00, setpoint_q}) - $signed({5'b00000, cfg.step});
            end
            // Clamp to max first, then min, so min wins when the limits cross
            if (sp_step >= $signed({2'b00, cfg.sp_max})) begin
              sp_step = $signed({2'b00, cfg.sp_max});
            end
            if (sp_step <= $signed({2'b00, cfg.sp_min})) begin
              sp_step = $signed({2'b00, cfg.sp_min});
            end
            setpoint_d = sp_step[SP_W-1:0];
            secs_d     = '0;
          end
        end
        ACT_SECOND: begin
          run = 1'b1;
          if (setting_q) begin
            secs_d = secs_inc;
            if (secs_inc > cfg.timeout) begin
              setting_d = 1'b0;
              secs_d    = '0;
              store     = 1'b1;
            end
          end
        end
        ACT_BLINK: begin
          run   = 1'b1;
          blink = 1'b1;
        end
        ACT_POWER: begin
          setting_d = 1'b0;
          secs_d    = '0;
          mode_d    = MODE_OFF;
          heater_d  = 1'b0;
          fan_d     = 1'b0;
          led_d     = 1'b0;
        end
        default: ;
      endcase
    end

    if (run) begin
      avg_s = $signed({2'b00, win.avg});
      hi_s  = $signed({4'b0000, setpoint_d}) + $signed({6'b000000, cfg.band});
      lo_s  = $signed({4'b0000, setpoint_d}) - $signed({6'b000000, cfg.band});
      if (!win.warmup && !setting_d) begin
        if (avg_s >= hi_s) begin
          fan_d    = 1'b1;
          heater_d = 1'b0;
          mode_d   = MODE_COOL;
        end
        // Heating is checked last so it wins on a zero band
        if (avg_s <= lo_s) begin
          heater_d = 1'b1;
          fan_d    = 1'b0;
          mode_d   = MODE_HEAT;
        end
      end else if (!win.warmup) begin
        heater_d = 1'b0;
        fan_d    = 1'b0;
        mode_d   = MODE_OFF;
      end
      // LED: dark when idle, lit when cooling, blinking when heating
      if (win.warmup) begin
        led_d = 1'b0;
      end else begin
        unique case (mode_d)
          MODE_OFF:  led_d = 1'b0;
          MODE_HEAT: led_d = blink ? !led_q : led_q;
          MODE_COOL: led_d = 1'b1;
          default:   led_d = led_q;
        endcase
      end
    end
  end

  always_comb begin
    rsp.heater_on       = heater_d;
    rsp.fan_on          = fan_d;
    rsp.led_on          = led_d;
    rsp.heat_cool_mode  = mode_d;
    rsp.setting_active  = setting_d;
    rsp.setpoint        = setpoint_d;
    rsp.avg_temperature = win.avg;
    rsp.warming_up      = win.warmup;
    rsp.store_request   = store;
  end

  // Output register with skid entry: advance the skid when the output drains
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        out_d = rsp;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_d       = rsp;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = rsp;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setting_q    <= 1'b0;
      secs_q       <= '0;
      setpoint_q   <= RST_INIT_SP;
      mode_q       <= MODE_OFF;
      heater_q     <= 1'b0;
      fan_q        <= 1'b0;
      led_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      setting_q    <= setting_d;
      secs_q       <= secs_d;
      setpoint_q   <= setpoint_d;
      mode_q       <= mode_d;
      heater_q     <= heater_d;
      fan_q        <= fan_d;
      led_q        <= led_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Skid entry only fills behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full with empty output register");

  // Heater and fan are never driven together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.heater_on && out_rsp_o.fan_on))
    else $error("heater and fan both on");

  // A store request marks the end of setting mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.store_request |-> !out_rsp_o.setting_active)
    else $error("store request while still in setting mode");

  // LED stays dark while the drive is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.heat_cool_mode == MODE_OFF) |-> !out_rsp_o.led_on)
    else $error("LED lit with drive off");

endmodule

### sim/averaged_hysteresis_thermostat_core_tb.sv
`timescale 1ns / 1ps

module averaged_hysteresis_thermostat_core_tb;
  import ahts_pkg::*;

  // Key and action codes that the package leaves unnamed
  localparam logic [1:0] KEY_NONE       = 2'd0;
  localparam logic [1:0] KEY_BOTH       = 2'd3;
  localparam logic [2:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI  = 3'd7;

  localparam int IDLE_PCT     = 37;
  localparam int HOLDOFF_CYC  = 60;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  ahts_in_t              in_req_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  ahts_out_t             out_rsp_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  averaged_hysteresis_thermostat_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Thermostat predictor: own copy of the registers and of the control state
  // --------------------------------------------------------------------------
  ahts_cfg_t              cfg_q;
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW_LEN];
  int                     ring_pos;
  int                     window_sum;
  int                     sp_now;
  int                     secs_now;
  logic                   warm;
  logic                   adjusting;
  logic                   heat;
  logic                   fan;
  logic                   led;
  ahts_mode_e             drive;

  // Readings still owed by the block, oldest first
  ahts_out_t              readings_due [$];

  // Bookkeeping
  int  errors = 0;
  int  requests_sent = 0;
  int  readings_checked = 0;
  int  reg_writes = 0;
  int  settings_used = 0;
  int  heat_seen = 0;
  int  cool_seen = 0;
  int  stores_seen = 0;
  int  drift_level = 120;
  bit  steady = 1'b0;
  int  hold_left = 0;

  function automatic int avg_degrees();
    return (window_sum * 25) >>> 9;
  endfunction

  // Push one converter reading into the window and advance the ring
  function automatic void absorb_reading(logic [SAMPLE_BITS-1:0] v);
    if (!warm) window_sum -= ring_q[ring_pos];
    ring_q[ring_pos] = v;
    window_sum += v;
    ring_pos++;
    if (ring_pos >= WINDOW_LEN) begin
      warm = 1'b0;
      ring_pos = 0;
    end
  endfunction

  // Bang-bang control with hysteresis, then the LED rule
  function automatic void regulate(logic blink);
    int avg;
    int band;
    avg  = avg_degrees();
    band = cfg_q.band;
    if (!warm && !adjusting) begin
      if (avg >= sp_now + band) begin
        fan = 1'b1; heat = 1'b0; drive = MODE_COOL;
      end
      // checked second so heating wins when the band is zero
      if (avg <= sp_now - band) begin
        heat = 1'b1; fan = 1'b0; drive = MODE_HEAT;
      end
    end else if (!warm) begin
      heat = 1'b0; fan = 1'b0; drive = MODE_OFF;
    end
    if (warm || drive == MODE_OFF) led = 1'b0;
    else if (drive == MODE_HEAT) begin
      if (blink) led = ~led;
    end else led = 1'b1;
  endfunction

  function automatic ahts_out_t thermostat_step(ahts_in_t req);
    ahts_out_t o;
    logic      store;
    int        sp_next;
    int        lo;
    int        hi;
    int        limit;
    store = 1'b0;
    lo    = cfg_q.sp_min;
    hi    = cfg_q.sp_max;
    limit = cfg_q.timeout;
    case (req.action)
      ACT_SAMPLE: begin
        // hold the window while the setpoint is being adjusted, until resume
        if (!(adjusting && secs_now < int'(cfg_q.resume))) absorb_reading(req.adc_sample);
        regulate(1'b0);
      end
      ACT_KEY: begin
        if (!adjusting) adjusting = 1'b1;
        else begin
          sp_next = sp_now;
          if (req.key == KEY_UP) sp_next += int'(cfg_q.step);
          else if (req.key == KEY_DOWN) sp_next -= int'(cfg_q.step);
          // max first, then min: min wins on an inverted pair
          if (sp_next >= hi) sp_next = hi;
          if (sp_next <= lo) sp_next = lo;
          sp_now   = sp_next & 'h7F;
          secs_now = 0;
        end
        regulate(1'b0);
      end
      ACT_SECOND: begin
        if (adjusting) begin
          if (secs_now < int'(SECS_MAX)) secs_now++;
          if (secs_now > limit) begin
            adjusting = 1'b0;
            secs_now  = 0;
            store     = 1'b1;
          end
        end
        regulate(1'b0);
      end
      ACT_BLINK: regulate(1'b1);
      ACT_POWER: begin
        ring_pos = 0; window_sum = 0; warm = 1'b1;
        adjusting = 1'b0; secs_now = 0;
        drive = MODE_OFF; heat = 1'b0; fan = 1'b0; led = 1'b0;
      end
      default: ;
    endcase
    o.heater_on       = heat;
    o.fan_on          = fan;
    o.led_on          = led;
    o.heat_cool_mode  = drive;
    o.setting_active  = adjusting;
    o.setpoint        = sp_now[SP_W-1:0];
    o.avg_temperature = AVG_W'(avg_degrees());
    o.warming_up      = warm;
    o.store_request   = store;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t after %0d readings: %s got %0d want %0d",
             $realtime, readings_checked, what, got, want);
    errors++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Take each accepted reading and hold it against the oldest prediction
  always @(posedge clk_i) begin : check_readings
    ahts_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (readings_due.size() == 0) begin
        report_mismatch("reading with no request pending", 1, 0);
      end else begin
        want = readings_due.pop_front();
        compare_field("heater_on", out_rsp_o.heater_on, want.heater_on);
        compare_field("fan_on", out_rsp_o.fan_on, want.fan_on);
        compare_field("led_on", out_rsp_o.led_on, want.led_on);
        compare_field("heat_cool_mode", out_rsp_o.heat_cool_mode, want.heat_cool_mode);
        compare_field("setting_active", out_rsp_o.setting_active, want.setting_active);
        compare_field("setpoint", out_rsp_o.setpoint, want.setpoint);
        compare_field("avg_temperature", out_rsp_o.avg_temperature,
                      want.avg_temperature);
        compare_field("warming_up", out_rsp_o.warming_up, want.warming_up);
        compare_field("store_request", out_rsp_o.store_request, want.store_request);
        if (want.heat_cool_mode == MODE_HEAT) heat_seen++;
        if (want.heat_cool_mode == MODE_COOL) cool_seen++;
        if (want.store_request) stores_seen++;
      end
      readings_checked++;
    end
  end

  // Receiver: stall at random, hold off for a counted stretch on request,
  // and drop stalls entirely during steady stretches
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic ahts_in_t req_of(logic [2:0] action, int adc, logic [1:0] key);
    ahts_in_t r;
    r.action     = action;
    r.adc_sample = adc[SAMPLE_BITS-1:0];
    r.key        = key;
    return r;
  endfunction

  // Enter with the clock low; leave at the falling edge after acceptance with valid
  // dropped, so a back-to-back caller raises it again in the same step
  task automatic send_request(input ahts_in_t req);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT)
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    in_req_i   = req;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    readings_due.push_back(thermostat_step(req));
    requests_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Mostly samples that hover around the setpoint so both thresholds get
  // crossed, with keys, ticks, rare power-offs and unused actions mixed in
  function automatic ahts_in_t next_random_request();
    ahts_in_t r;
    int       pick;
    int       v;
    r.adc_sample = SAMPLE_BITS'($urandom_range(0, 1023));
    r.key        = 2'($urandom_range(0, 3));
    pick         = $urandom_range(0, 99);
    if (pick < 52) begin
      r.action = ACT_SAMPLE;
      if ($urandom_range(0, 99) < 12)
        drift_level = sp_now * 2 + int'($urandom_range(0, 80)) - 40;
      else
        drift_level = drift_level + int'($urandom_range(0, 16)) - 8;
      if (drift_level < 0) drift_level = 0;
      if (drift_level > 1023) drift_level = 1023;
      // keep one sample in ten fully random to reach the field extremes
      if ($urandom_range(0, 9) != 0) begin
        v = drift_level + int'($urandom_range(0, 48)) - 24;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        r.adc_sample = SAMPLE_BITS'(v);
      end
    end else if (pick < 64) begin
      r.action = ACT_KEY;
    end else if (pick < 78) begin
      r.action = ACT_SECOND;
    end else if (pick < 91) begin
      r.action = ACT_BLINK;
    end else if (pick < 92) begin
      r.action = ACT_POWER;
    end else if (pick < 96) begin
      r.action = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end else begin
      r.action = ACT_SAMPLE;
    end
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(next_random_request());
  endtask

  // Wait until every owed reading has come back, then let the pipe go quiet
  task automatic settle();
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic check_reg(logic [2:0] idx, logic [31:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) report_mismatch($sformatf("register %0d readback", idx),
                                         prdata, want);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write one register, mirror it in the predictor, read it back
  task automatic program_reg(logic [2:0] idx, int value);
    logic [31:0] held;
    case (idx)
      REG_BAND: begin
        cfg_q.band = BAND_W'(value);
        held = APB_DATA_W'(cfg_q.band);
      end
      REG_STEP: begin
        cfg_q.step = STEP_W'(value);
        held = APB_DATA_W'(cfg_q.step);
      end
      REG_SP_MIN: begin
        cfg_q.sp_min = SP_W'(value);
        held = APB_DATA_W'(cfg_q.sp_min);
      end
      REG_SP_MAX: begin
        cfg_q.sp_max = SP_W'(value);
        held = APB_DATA_W'(cfg_q.sp_max);
      end
      REG_TIMEOUT: begin
        cfg_q.timeout = SECS_W'(value);
        held = APB_DATA_W'(cfg_q.timeout);
      end
      REG_RESUME: begin
        cfg_q.resume = SECS_W'(value);
        held = APB_DATA_W'(cfg_q.resume);
      end
      default: begin
        cfg_q.init_sp = SP_W'(value);
        held = APB_DATA_W'(cfg_q.init_sp);
      end
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = held;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
    check_reg(idx, held);
  endtask

  task automatic apply_settings(int band, int step, int lo, int hi,
                                int tmo, int resume, int init_sp);
    settle();
    program_reg(REG_BAND, band);
    program_reg(REG_STEP, step);
    program_reg(REG_SP_MIN, lo);
    program_reg(REG_SP_MAX, hi);
    program_reg(REG_TIMEOUT, tmo);
    program_reg(REG_RESUME, resume);
    // the setpoint loads RST_INIT_SP at reset, not this register, so no effect on the predictor state
    program_reg(REG_INIT_SP, init_sp);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_reset();
    check_reg(REG_BAND, RST_BAND);
    check_reg(REG_STEP, RST_STEP);
    check_reg(REG_SP_MIN, RST_SP_MIN);
    check_reg(REG_SP_MAX, RST_SP_MAX);
    check_reg(REG_TIMEOUT, RST_TIMEOUT);
    check_reg(REG_RESUME, RST_RESUME);
    check_reg(REG_INIT_SP, RST_INIT_SP);
  endtask

  // Walk the defaults: fill the window hot, adjust the setpoint through its
  // clamp, time out the adjust mode, then unused actions and power-off
  task automatic test_directed_walkthrough();
    int fill [WINDOW_LEN] = '{1023, 0, 1023, 1023, 512, 0, 1023, 341, 682, 1023};
    foreach (fill[i]) send_request(req_of(ACT_SAMPLE, fill[i], KEY_NONE));
    send_request(req_of(ACT_BLINK, 0, KEY_BOTH));
    // first key only enters adjust mode
    send_request(req_of(ACT_KEY, 0, KEY_NONE));
    // dropped from the window while adjusting
    send_request(req_of(ACT_SAMPLE, 1023, KEY_NONE));
    send_request(req_of(ACT_KEY, 0, KEY_UP));
    send_request(req_of(ACT_KEY, 0, KEY_UP));
    send_request(req_of(ACT_KEY, 0, KEY_DOWN));
    // neither key: clears the seconds and reapplies the clamp
    send_request(req_of(ACT_KEY, 1023, KEY_BOTH));
    // default timeout ends adjust mode on the sixth tick with a store request
    repeat (6) send_request(req_of(ACT_SECOND, 0, KEY_NONE));
    // tick with adjust mode off does nothing
    send_request(req_of(ACT_SECOND, 0, KEY_NONE));
    send_request(req_of(ACT_UNUSED_LO, 1023, KEY_BOTH));
    send_request(req_of(ACT_UNUSED_HI, 0, KEY_NONE));
    send_request(req_of(ACT_POWER, 1023, KEY_BOTH));
  endtask

  // Run traffic under the register extremes, an inverted clamp pair,
  // a random setting, and back to the defaults
  task automatic test_register_extremes();
    apply_settings(0, 15, 0, 127, 0, 0, 0);
    run_random(150);
    apply_settings(31, 1, 127, 0, 15, 15, 127);
    run_random(150);
    apply_settings($urandom_range(0, 31), $urandom_range(1, 15),
                   $urandom_range(0, 60), $urandom_range(60, 127),
                   $urandom_range(0, 14), $urandom_range(0, 15),
                   $urandom_range(0, 127));
    run_random(150);
    apply_settings(RST_BAND, RST_STEP, RST_SP_MIN, RST_SP_MAX,
                   RST_TIMEOUT, RST_RESUME, RST_INIT_SP);
    run_random(150);
  endtask

  // Hold the result side off while requests keep coming, so the output stage
  // fills and the block stalls its request side; then pause until drained
  task automatic test_output_holdoff();
    settle();
    steady    = 1'b1;
    hold_left = HOLDOFF_CYC;
    run_random(40);
    steady = 1'b0;
    settle();
  endtask

  task automatic test_random_traffic();
    // stretch with no idling on either side
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;
    run_random(300);
    settle();
    run_random(250);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_q.band    = RST_BAND;
    cfg_q.step    = RST_STEP;
    cfg_q.sp_min  = RST_SP_MIN;
    cfg_q.sp_max  = RST_SP_MAX;
    cfg_q.timeout = RST_TIMEOUT;
    cfg_q.resume  = RST_RESUME;
    cfg_q.init_sp = RST_INIT_SP;
    foreach (ring_q[i]) ring_q[i] = '0;
    ring_pos   = 0;
    window_sum = 0;
    warm       = 1'b1;
    adjusting  = 1'b0;
    secs_now   = 0;
    sp_now     = int'(RST_INIT_SP);
    drive      = MODE_OFF;
    heat       = 1'b0;
    fan        = 1'b0;
    led        = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_reset();
    test_directed_walkthrough();
    test_register_extremes();
    test_output_holdoff();
    test_random_traffic();

    // drain, then let the output register go quiet
    while (readings_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d requests and %0d checked readings over %0d register settings",
             requests_sent, readings_checked, settings_used);
    $display("with %0d register writes, %0d heating, %0d cooling, %0d store readings.",
             reg_writes, heat_seen, cool_seen, stores_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ahts_pkg.sv
rtl/core/ahts_cell.sv
rtl/core/ahts_window.sv
rtl/core/ahts_apb_regs.sv
rtl/core/averaged_hysteresis_thermostat_core.sv
sim/averaged_hysteresis_thermostat_core_tb.sv
